FILE: hw/rtl/lfcc_pkg.sv
// lfcc_pkg: sizes, widths and shared types of the line fit cluster cost block
// used by lfcc_div and line_fit_cluster_cost; depends on nothing else
package lfcc_pkg;

    localparam int MAX_POINTS = 256;
    localparam int ADDR_W     = $clog2(MAX_POINTS);
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);
    localparam int COORD_W    = 16;

    localparam int SUM_W      = COORD_W + CNT_W;        // running coordinate sums
    localparam int MEAN_W     = COORD_W + 1;
    localparam int DELTA_W    = COORD_W + 2;
    localparam int SQ_W       = 2 * DELTA_W;            // one squared delta
    localparam int ACC_W      = SQ_W + CNT_W + 1;       // sxx, sxy
    localparam int DIST_W     = DELTA_W + CNT_W;
    localparam int SLOPE_W    = 34;                     // |sxy| / sxx <= 65535, so slope < 2^32
    localparam int ERR_W      = 26;
    localparam int RES_W      = 2 * ERR_W;
    localparam int MUL_A_W    = SLOPE_W;
    localparam int MUL_B_W    = ERR_W;
    localparam int PROD_W     = MUL_A_W + MUL_B_W;

    localparam int DVD_W      = 57;                     // dividend of the shared divider
    localparam int DVS_W      = 41;                     // divisor
    localparam int DIV_CNT_W  = $clog2(DVD_W + 1);

    localparam int COST_W     = 40;
    localparam int TDATA_IN_W = 32;
    localparam int TDATA_OUT_W = 56;

    localparam int ISQRT_STEPS = DELTA_W - 1;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

FILE: hw/rtl/lfcc_div.sv
// lfcc_div: restoring divider, one quotient bit per cycle, unsigned operands
// depends on lfcc_pkg for operand widths and the status struct
module lfcc_div (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [lfcc_pkg::DVD_W-1:0]    dividend,
    input  logic [lfcc_pkg::DVS_W-1:0]    divisor,
    output lfcc_pkg::div_status_t         status,
    output logic [lfcc_pkg::DVD_W-1:0]    quotient,
    output logic                          rem_nonzero
);

    logic [lfcc_pkg::DVS_W:0]           rem_reg, rem_next;
    logic [lfcc_pkg::DVD_W-1:0]         quo_reg, quo_next;
    logic [lfcc_pkg::DVS_W-1:0]         dvs_reg;
    logic [lfcc_pkg::DIV_CNT_W-1:0]     cnt_reg, cnt_next;
    logic                               busy_reg, busy_next;
    logic                               done_reg, done_next;
    logic [lfcc_pkg::DVS_W+1:0]         trial;

    always_comb begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg, quo_reg[lfcc_pkg::DVD_W-1]} - {2'b00, dvs_reg};
        if (start) begin
            rem_next  = '0;
            quo_next  = dividend;
            cnt_next  = lfcc_pkg::DIV_CNT_W'(lfcc_pkg::DVD_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (!trial[lfcc_pkg::DVS_W+1]) begin
                rem_next = trial[lfcc_pkg::DVS_W:0];
                quo_next = {quo_reg[lfcc_pkg::DVD_W-2:0], 1'b1};
            end else begin
                rem_next = {rem_reg[lfcc_pkg::DVS_W-1:0], quo_reg[lfcc_pkg::DVD_W-1]};
                quo_next = {quo_reg[lfcc_pkg::DVD_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == lfcc_pkg::DIV_CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        if (start) begin
            dvs_reg <= divisor;
        end
    end

    assign status.busy  = busy_reg;
    assign status.done  = done_reg;
    assign quotient     = quo_reg;
    assign rem_nonzero  = (rem_reg != '0);

endmodule

FILE: hw/rtl/line_fit_cluster_cost.sv
// line_fit_cluster_cost: top level, point store, passes over it and the sequencer
// depends on lfcc_pkg and lfcc_div
//
// usage:
//   s_ channel carries one point per transfer: s_tdata holds point_x and
//   point_y, s_tlast marks the final point of a set. points load one per
//   cycle into a 256 entry store; points beyond that are dropped and flag
//   overflow. the transfer with s_tlast closes the set.
//   m_ channel carries one result per set: fit_cost, points_used, overflowed.
//   after the closing point the block computes, with s_tready low:
//     two mean divisions
//     fit pass over every stored point, each with a square root
//     slope division, skipped when the variance is zero
//     residual pass over every stored point
//     cost division, then loading of the output register
//   the time from the closing transfer to m_tvalid is set by the bit-serial
//   divider and square root and the single memory port.
//   the result sits in an output register; loading of the next set starts at
//   once and continues while the receiver stalls. a second result waits for
//   the register to drain.
//   reset (aresetn low, synchronous) empties the set and drops m_tvalid; the
//   store content is not cleared and is never read before it is written.
module line_fit_cluster_cost (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [15:0] point_x, [31:16] point_y
    input  logic        s_tlast,   // last_point
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata    // [39:0] fit_cost, [48:40] points_used, [49] overflowed
);

    typedef enum logic [4:0] {
        S_LOAD, S_MX, S_MX_W, S_MY, S_MY_W,
        S_B_RD, S_B_DAT, S_B_XX, S_B_XY, S_B_YY, S_B_SQ0, S_B_SQ,
        S_SLOPE, S_SLOPE_W,
        S_C_RD, S_C_DAT, S_C_MUL, S_C_ERR, S_C_SQ, S_C_ACC,
        S_COST, S_COST_W, S_OUT
    } state_t;

    localparam int AW = lfcc_pkg::ADDR_W;
    localparam int CW = lfcc_pkg::CNT_W;
    localparam int KW = lfcc_pkg::COORD_W;

    state_t state_reg;

    // point store: x in the low half, y in the high half
    logic [2*KW-1:0] mem [lfcc_pkg::MAX_POINTS];
    logic [2*KW-1:0] rd_data_reg;
    logic            wr_en;
    logic [AW-1:0]   rd_addr;

    logic [CW-1:0]   cnt_reg;
    logic            ovf_reg;
    logic [CW-1:0]   idx_reg;
    logic signed [lfcc_pkg::SUM_W-1:0]   sx_reg, sy_reg;
    logic signed [lfcc_pkg::MEAN_W-1:0]  mx_reg, my_reg;
    logic signed [lfcc_pkg::DELTA_W-1:0] dx_reg, dy_reg;
    logic [lfcc_pkg::SQ_W-1:0]           dx2_reg;
    logic [lfcc_pkg::ACC_W-1:0]          sxx_reg;
    logic signed [lfcc_pkg::ACC_W-1:0]   sxy_reg;
    logic [lfcc_pkg::DIST_W-1:0]         dist_reg;
    logic signed [lfcc_pkg::SLOPE_W-1:0] slope_reg;
    logic signed [lfcc_pkg::ERR_W-1:0]   err_reg;
    logic [lfcc_pkg::RES_W-1:0]          res_reg;
    logic [lfcc_pkg::COST_W-1:0]         cost_reg;

    logic [lfcc_pkg::SQ_W-1:0]  sq_v_reg, sq_root_reg, sq_bit_reg;
    logic [4:0]                 sq_cnt_reg;
    logic [lfcc_pkg::SQ_W:0]    sq_trial;

    logic signed [lfcc_pkg::MUL_A_W-1:0] mul_a;
    logic signed [lfcc_pkg::MUL_B_W-1:0] mul_b;
    logic signed [lfcc_pkg::PROD_W-1:0]  prod_reg;

    logic                         div_start;
    logic [lfcc_pkg::DVD_W-1:0]   div_dvd;
    logic [lfcc_pkg::DVS_W-1:0]   div_dvs;
    lfcc_pkg::div_status_t        div_st;
    logic [lfcc_pkg::DVD_W-1:0]   div_q;
    logic                         div_rnz;
    logic                         div_neg_reg;

    logic signed [KW-1:0]         in_x, in_y, rd_x, rd_y;
    logic signed [lfcc_pkg::SUM_W+1:0]   mean_num;
    logic [lfcc_pkg::SUM_W+1:0]          mean_mag;
    logic signed [lfcc_pkg::MEAN_W:0]    mean_q;
    logic [lfcc_pkg::ACC_W-1:0]          sxy_mag;
    logic [lfcc_pkg::DVD_W-1:0]          slope_mag;
    logic signed [lfcc_pkg::PROD_W-1:0]  fit_wide;
    logic signed [lfcc_pkg::PROD_W-1:0]  err_wide;
    logic [lfcc_pkg::DVD_W-1:0]          cost_num;
    logic [lfcc_pkg::COST_W-1:0]         cost_sat;
    logic                                s_xfer;

    localparam logic [lfcc_pkg::DVD_W-1:0] SLOPE_CAP = lfcc_pkg::DVD_W'(64'd1 << 40);
    localparam logic signed [lfcc_pkg::ERR_W-1:0] ERR_HI = {1'b0, {(lfcc_pkg::ERR_W-1){1'b1}}};
    localparam logic signed [lfcc_pkg::ERR_W-1:0] ERR_LO = {1'b1, {(lfcc_pkg::ERR_W-1){1'b0}}};

    assign in_x   = s_tdata[KW-1:0];
    assign in_y   = s_tdata[2*KW-1:KW];
    assign rd_x   = rd_data_reg[KW-1:0];
    assign rd_y   = rd_data_reg[2*KW-1:KW];
    assign s_tready = (state_reg == S_LOAD);
    assign s_xfer = s_tvalid && s_tready;
    assign wr_en  = s_xfer && (cnt_reg != CW'(lfcc_pkg::MAX_POINTS));
    assign rd_addr = idx_reg[AW-1:0];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[cnt_reg[AW-1:0]] <= s_tdata[2*KW-1:0];
        end
        rd_data_reg <= mem[rd_addr];
    end

    lfcc_div u_div (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .start       (div_start),
        .dividend    (div_dvd),
        .divisor     (div_dvs),
        .status      (div_st),
        .quotient    (div_q),
        .rem_nonzero (div_rnz)
    );

    // divider operands per phase
    always_comb begin
        div_start = 1'b0;
        div_dvd   = '0;
        div_dvs   = lfcc_pkg::DVS_W'({cnt_reg, 1'b0});
        mean_num  = (state_reg == S_MX)
                  ? (lfcc_pkg::SUM_W+2)'(sx_reg) * 2 + (lfcc_pkg::SUM_W+2)'({1'b0, cnt_reg})
                  : (lfcc_pkg::SUM_W+2)'(sy_reg) * 2 + (lfcc_pkg::SUM_W+2)'({1'b0, cnt_reg});
        mean_mag  = mean_num[lfcc_pkg::SUM_W+1] ? 0 - mean_num : mean_num;
        sxy_mag   = sxy_reg[lfcc_pkg::ACC_W-1] ? 0 - sxy_reg : sxy_reg;
        cost_num  = lfcc_pkg::DVD_W'({dist_reg, 8'd0}) + lfcc_pkg::DVD_W'(res_reg)
                  + lfcc_pkg::DVD_W'({cnt_reg, 7'd0});
        case (state_reg)
            S_MX, S_MY: begin
                div_start = 1'b1;
                div_dvd   = lfcc_pkg::DVD_W'(mean_mag);
            end
            S_SLOPE: begin
                div_start = (sxx_reg != '0);
                div_dvd   = lfcc_pkg::DVD_W'({sxy_mag, 16'd0});
                div_dvs   = lfcc_pkg::DVS_W'(sxx_reg);
            end
            S_COST: begin
                div_start = 1'b1;
                div_dvd   = cost_num;
                div_dvs   = lfcc_pkg::DVS_W'({cnt_reg, 8'd0});
            end
            default: ;
        endcase
    end

    // floor division result of a mean, sign taken from the numerator; capped slope magnitude; saturated cost
    always_comb begin
        mean_q = div_neg_reg
               ? 0 - (lfcc_pkg::MEAN_W+1)'(div_q) - (lfcc_pkg::MEAN_W+1)'(div_rnz)
               : (lfcc_pkg::MEAN_W+1)'(div_q);
        slope_mag = (div_q > SLOPE_CAP) ? SLOPE_CAP : div_q;
        cost_sat  = (div_q > lfcc_pkg::DVD_W'({lfcc_pkg::COST_W{1'b1}}))
                  ? {lfcc_pkg::COST_W{1'b1}} : div_q[lfcc_pkg::COST_W-1:0];
    end

    // shared multiplier operands
    always_comb begin
        mul_a = lfcc_pkg::MUL_A_W'(dx_reg);
        mul_b = lfcc_pkg::MUL_B_W'(dx_reg);
        case (state_reg)
            S_B_XY:  mul_b = lfcc_pkg::MUL_B_W'(dy_reg);
            S_B_YY: begin
                mul_a = lfcc_pkg::MUL_A_W'(dy_reg);
                mul_b = lfcc_pkg::MUL_B_W'(dy_reg);
            end
            S_C_MUL: mul_a = slope_reg;
            S_C_SQ: begin
                mul_a = lfcc_pkg::MUL_A_W'(err_reg);
                mul_b = err_reg;
            end
            default: ;
        endcase
    end

    always_comb begin
        sq_trial = {1'b0, sq_v_reg} - ({1'b0, sq_root_reg} + {1'b0, sq_bit_reg});
        fit_wide = (prod_reg + lfcc_pkg::PROD_W'(32768)) >>> 16;
        err_wide = lfcc_pkg::PROD_W'(dy_reg) - fit_wide;
    end

    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
        if (!aresetn) begin
            state_reg   <= S_LOAD;
            cnt_reg     <= '0;
            ovf_reg     <= 1'b0;
            sx_reg      <= '0;
            sy_reg      <= '0;
            idx_reg     <= '0;
            m_tvalid    <= 1'b0;
            sq_cnt_reg  <= '0;
        end else begin
            if (m_tvalid && m_tready && (state_reg != S_OUT)) begin
                m_tvalid <= 1'b0;
            end
            case (state_reg)
                S_LOAD: begin
                    if (s_xfer) begin
                        if (wr_en) begin
                            cnt_reg <= cnt_reg + 1'b1;
                            sx_reg  <= sx_reg + lfcc_pkg::SUM_W'(in_x);
                            sy_reg  <= sy_reg + lfcc_pkg::SUM_W'(in_y);
                        end else begin
                            ovf_reg <= 1'b1;
                        end
                        if (s_tlast) begin
                            state_reg <= S_MX;
                        end
                    end
                end
                S_MX: begin
                    div_neg_reg <= mean_num[lfcc_pkg::SUM_W+1];
                    state_reg   <= S_MX_W;
                end
                S_MX_W: begin
                    if (div_st.done) begin
                        mx_reg    <= mean_q[lfcc_pkg::MEAN_W-1:0];
                        state_reg <= S_MY;
                    end
                end
                S_MY: begin
                    div_neg_reg <= mean_num[lfcc_pkg::SUM_W+1];
                    state_reg   <= S_MY_W;
                end
                S_MY_W: begin
                    if (div_st.done) begin
                        my_reg    <= mean_q[lfcc_pkg::MEAN_W-1:0];
                        idx_reg   <= '0;
                        sxx_reg   <= '0;
                        sxy_reg   <= '0;
                        dist_reg  <= '0;
                        state_reg <= S_B_RD;
                    end
                end
                S_B_RD: state_reg <= S_B_DAT;
                S_B_DAT: begin
                    dx_reg    <= lfcc_pkg::DELTA_W'(rd_x) - lfcc_pkg::DELTA_W'(mx_reg);
                    dy_reg    <= lfcc_pkg::DELTA_W'(rd_y) - lfcc_pkg::DELTA_W'(my_reg);
                    state_reg <= S_B_XX;
                end
                S_B_XX: state_reg <= S_B_XY;
                S_B_XY: begin
                    dx2_reg   <= prod_reg[lfcc_pkg::SQ_W-1:0];
                    sxx_reg   <= sxx_reg + lfcc_pkg::ACC_W'(prod_reg[lfcc_pkg::SQ_W-1:0]);
                    state_reg <= S_B_YY;
                end
                S_B_YY: begin
                    sxy_reg   <= sxy_reg + lfcc_pkg::ACC_W'(prod_reg);
                    state_reg <= S_B_SQ0;
                end
                S_B_SQ0: begin
                    sq_v_reg    <= dx2_reg + prod_reg[lfcc_pkg::SQ_W-1:0];
                    sq_root_reg <= '0;
                    sq_bit_reg  <= lfcc_pkg::SQ_W'(64'd1 << (2 * (lfcc_pkg::ISQRT_STEPS - 1)));
                    sq_cnt_reg  <= 5'(lfcc_pkg::ISQRT_STEPS);
                    state_reg   <= S_B_SQ;
                end
                S_B_SQ: begin
                    if (!sq_trial[lfcc_pkg::SQ_W]) begin
                        sq_v_reg    <= sq_trial[lfcc_pkg::SQ_W-1:0];
                        sq_root_reg <= (sq_root_reg >> 1) + sq_bit_reg;
                    end else begin
                        sq_root_reg <= sq_root_reg >> 1;
                    end
                    sq_bit_reg <= sq_bit_reg >> 2;
                    sq_cnt_reg <= sq_cnt_reg - 1'b1;
                    if (sq_cnt_reg == 5'd0) begin
                        dist_reg <= dist_reg + lfcc_pkg::DIST_W'(sq_root_reg);
                        idx_reg  <= idx_reg + 1'b1;
                        state_reg <= (idx_reg + 1'b1 == cnt_reg) ? S_SLOPE : S_B_RD;
                    end
                end
                S_SLOPE: begin
                    div_neg_reg <= sxy_reg[lfcc_pkg::ACC_W-1];
                    idx_reg     <= '0;
                    res_reg     <= '0;
                    if (sxx_reg == '0) begin
                        slope_reg <= '0;
                        state_reg <= S_C_RD;
                    end else begin
                        state_reg <= S_SLOPE_W;
                    end
                end
                S_SLOPE_W: begin
                    if (div_st.done) begin
                        slope_reg <= div_neg_reg
                                   ? 0 - lfcc_pkg::SLOPE_W'(slope_mag)
                                   : lfcc_pkg::SLOPE_W'(slope_mag);
                        state_reg <= S_C_RD;
                    end
                end
                S_C_RD: state_reg <= S_C_DAT;
                S_C_DAT: begin
                    dx_reg    <= lfcc_pkg::DELTA_W'(rd_x) - lfcc_pkg::DELTA_W'(mx_reg);
                    dy_reg    <= lfcc_pkg::DELTA_W'(rd_y) - lfcc_pkg::DELTA_W'(my_reg);
                    state_reg <= S_C_MUL;
                end
                S_C_MUL: state_reg <= S_C_ERR;
                S_C_ERR: begin
                    // least-squares residual stays far inside this range
                    if (err_wide > lfcc_pkg::PROD_W'(ERR_HI)) begin
                        err_reg <= ERR_HI;
                    end else if (err_wide < lfcc_pkg::PROD_W'(ERR_LO)) begin
                        err_reg <= ERR_LO;
                    end else begin
                        err_reg <= err_wide[lfcc_pkg::ERR_W-1:0];
                    end
                    state_reg <= S_C_SQ;
                end
                S_C_SQ: state_reg <= S_C_ACC;
                S_C_ACC: begin
                    res_reg   <= res_reg + prod_reg[lfcc_pkg::RES_W-1:0];
                    idx_reg   <= idx_reg + 1'b1;
                    state_reg <= (idx_reg + 1'b1 == cnt_reg) ? S_COST : S_C_RD;
                end
                S_COST: state_reg <= S_COST_W;
                S_COST_W: begin
                    if (div_st.done) begin
                        cost_reg  <= cost_sat;
                        state_reg <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!m_tvalid || m_tready) begin
                        m_tvalid       <= 1'b1;
                        m_tdata[lfcc_pkg::COST_W-1:0] <= cost_reg;
                        m_tdata[48:40] <= cnt_reg;
                        m_tdata[49]    <= ovf_reg;
                        m_tdata[55:50] <= '0;
                        cnt_reg        <= '0;
                        ovf_reg        <= 1'b0;
                        sx_reg         <= '0;
                        sy_reg         <= '0;
                        state_reg      <= S_LOAD;
                    end
                end
                default: state_reg <= S_LOAD;
            endcase
        end
    end

endmodule

FILE: hw/rtl/lfcc_checker.sv
// lfcc_checker: port-level assertions for line_fit_cluster_cost, bound to the top
// depends on the top level's port list only
module lfcc_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [55:0] m_tdata
);

    // a stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    a_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[48:40] != 9'd0) && (m_tdata[48:40] <= 9'd256))
        else $error("points_used out of range");

    // dropped points only when the store is full
    a_ovf: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[49] |-> m_tdata[48:40] == 9'd256)
        else $error("overflow with free store entries");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // a new result is only issued while the input side is closed
    a_rise: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(!s_tready || !s_tvalid))
        else $error("result issued while points were loading");

endmodule

bind line_fit_cluster_cost lfcc_checker u_lfcc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
